// File: src/tvrl_pkg.sv
// ----------------------------------------------------------------------------
// tvrl_pkg
// Shared types and constants of the twist velocity ramp limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvrl_pkg;

  localparam int unsigned SPD_W  = 15;  // speed limit register width
  localparam int unsigned ACC_W  = 16;  // accel limit register width
  localparam int unsigned M_W    = 16;  // width of any limit (speed or step)
  localparam int unsigned BIT_W  = 4;   // counts the M_W result bits
  localparam int unsigned DT_W   = 20;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [DT_W-1:0] DT_DEFAULT_US = 20'd50000;
  localparam logic [DT_W-1:0] DT_MAX_US     = 20'd1000000;
  localparam logic [DT_W-1:0] DT_MIN_US     = 20'd1000;
  localparam int unsigned     US_PER_S      = 1000000;

  localparam logic [SPD_W-1:0] LIN_SPEED_RST = 15'd819;
  localparam logic [SPD_W-1:0] ANG_SPEED_RST = 15'd2048;
  localparam logic [ACC_W-1:0] LIN_ACCEL_RST = 16'd4096;
  localparam logic [ACC_W-1:0] ANG_ACCEL_RST = 16'd8192;

  localparam logic [1:0] REG_LIN_SPEED = 2'd0;
  localparam logic [1:0] REG_ANG_SPEED = 2'd1;
  localparam logic [1:0] REG_LIN_ACCEL = 2'd2;
  localparam logic [1:0] REG_ANG_ACCEL = 2'd3;

  typedef struct packed {
    logic [SPD_W-1:0] max_linear_speed;
    logic [SPD_W-1:0] max_angular_speed;
    logic [ACC_W-1:0] max_linear_accel;
    logic [ACC_W-1:0] max_angular_accel;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_INIT, ST_DIV, ST_SEL, ST_SQ, ST_ACC, ST_MSQ, ST_CMP,
    ST_TMUL, ST_TSQ, ST_BIT, ST_WR, ST_STORE, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RESET_HIST, OP_DIV_INIT, OP_DIV_BIT, OP_SEL, OP_SQ,
    OP_ACC, OP_MSQ, OP_CMP, OP_TMUL, OP_TSQ, OP_BIT, OP_WR, OP_STORE, OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [1:0]       idx;      // vector component
    logic [BIT_W-1:0] bit_idx;  // result bit under trial
    logic             ang;      // 0 linear, 1 angular
    logic             ramp;     // 0 speed clamp, 1 ramp step
  } cmd_t;

  typedef struct packed {
    logic over;      // squared norm above squared limit
    logic ramp_en;   // ramp step applies to this sample
  } sts_t;

endpackage

`default_nettype wire

// File: src/tvrl_in_if.sv
// ----------------------------------------------------------------------------
// tvrl_in_if
// Input channel: one velocity command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tvrl_in_if #(parameter int unsigned VEL_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [VEL_WIDTH-1:0] lin_x;
  logic signed [VEL_WIDTH-1:0] lin_y;
  logic signed [VEL_WIDTH-1:0] lin_z;
  logic signed [VEL_WIDTH-1:0] ang_x;
  logic signed [VEL_WIDTH-1:0] ang_y;
  logic signed [VEL_WIDTH-1:0] ang_z;
  logic [tvrl_pkg::DT_W-1:0]   elapsed_us;

  modport source (output valid, cmd, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                  elapsed_us, input ready);
  modport sink (input valid, cmd, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                elapsed_us, output ready);
endinterface

`default_nettype wire

// File: src/tvrl_out_if.sv
// ----------------------------------------------------------------------------
// tvrl_out_if
// Output channel: one limited velocity beat with clamp flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tvrl_out_if #(parameter int unsigned VEL_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] out_lin_x;
  logic signed [VEL_WIDTH-1:0] out_lin_y;
  logic signed [VEL_WIDTH-1:0] out_lin_z;
  logic signed [VEL_WIDTH-1:0] out_ang_x;
  logic signed [VEL_WIDTH-1:0] out_ang_y;
  logic signed [VEL_WIDTH-1:0] out_ang_z;
  logic                        lin_speed_clamped;
  logic                        ang_speed_clamped;
  logic                        lin_accel_clamped;
  logic                        ang_accel_clamped;

  modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x,
                  out_ang_y, out_ang_z, lin_speed_clamped, ang_speed_clamped,
                  lin_accel_clamped, ang_accel_clamped, input ready);
  modport sink (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x,
                out_ang_y, out_ang_z, lin_speed_clamped, ang_speed_clamped,
                lin_accel_clamped, ang_accel_clamped, output ready);
endinterface

`default_nettype wire

// File: src/tvrl_dp.sv
// ----------------------------------------------------------------------------
// tvrl_dp
// Datapath: shared multiplier, norm accumulator, bit-serial scaler, divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvrl_dp #(
  parameter int unsigned VEL_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  tvrl_pkg::cmd_t               cmd_i,
  output tvrl_pkg::sts_t               sts_o,
  input  tvrl_pkg::cfg_t               cfg_i,
  input  wire logic signed [VEL_WIDTH-1:0] in_vel_i [6],
  input  wire logic [tvrl_pkg::DT_W-1:0]   in_elapsed_i,
  output logic signed [VEL_WIDTH-1:0]      res_vel_o [6],
  output logic [3:0]                       res_flag_o
);

  localparam int unsigned VW   = VEL_WIDTH;
  localparam int unsigned MW   = tvrl_pkg::M_W;
  localparam int unsigned MA_W = VW + MW;
  localparam int unsigned PR_W = 2 * MA_W;
  localparam int unsigned S_W  = 2 * VW + 2;
  localparam int unsigned Q_W  = S_W + MW;
  localparam int unsigned PC_W = PR_W + 2;

  logic signed [VW-1:0] vel_q [6];
  logic signed [VW-1:0] prev_q [6];
  logic signed [VW:0]   work_q [3];
  logic                 first_q;
  logic                 ramp_en_q;
  logic [tvrl_pkg::DT_W-1:0] dt_q;
  logic [MW-1:0]        m_q;
  logic [MW-1:0]        r_q;
  logic [MW-1:0]        quo_q;
  logic [S_W-1:0]       s_q;
  logic [PR_W-1:0]      prod_q;
  logic                 over_q;
  logic [PC_W-1:0]      p_q;
  logic [Q_W-1:0]       q_q;
  logic [3:0]           flag_q;

  logic [VW-1:0]        mag_sel;
  logic [MA_W-1:0]      mul_a;
  logic [MA_W-1:0]      mul_b;
  logic [PR_W-1:0]      mul_p;
  logic [PR_W-1:0]      dvs;
  logic                 div_ge;
  logic [MW-1:0]        cand;
  logic [PC_W-1:0]      pc;
  logic                 take;
  logic [tvrl_pkg::DT_W-1:0] dt_eff;
  logic signed [VW:0]   sel_v [3];
  logic signed [VW:0]   store_v [3];

  function automatic logic [VW-1:0] mag_f(input logic signed [VW:0] a);
    logic [VW:0] u;
    u = a[VW] ? $unsigned(-a) : $unsigned(a);
    return u[VW-1:0];
  endfunction

  assign mag_sel = mag_f(work_q[cmd_i.idx]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tvrl_pkg::OP_SQ: begin
        mul_a = MA_W'(mag_sel);
        mul_b = MA_W'(mag_sel);
      end
      tvrl_pkg::OP_MSQ: begin
        mul_a = MA_W'(m_q);
        mul_b = MA_W'(m_q);
      end
      tvrl_pkg::OP_TMUL: begin
        mul_a = MA_W'(mag_sel);
        mul_b = MA_W'(m_q);
      end
      tvrl_pkg::OP_TSQ: begin
        mul_a = prod_q[MA_W-1:0];
        mul_b = prod_q[MA_W-1:0];
      end
      tvrl_pkg::OP_DIV_INIT: begin
        mul_a = MA_W'(cmd_i.ang ? cfg_i.max_angular_accel : cfg_i.max_linear_accel);
        mul_b = MA_W'(dt_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // restoring division of accel * dt by one second
  assign dvs    = PR_W'(tvrl_pkg::US_PER_S) << cmd_i.bit_idx;
  assign div_ge = prod_q >= dvs;

  // s * (r + 2^b)^2 = s*r^2 + (s*r) << (b+1) + s << 2b
  assign cand = r_q | (MW'(1) << cmd_i.bit_idx);
  assign pc   = p_q + (PC_W'(q_q) << ({1'b0, cmd_i.bit_idx} + 1'b1))
              + (PC_W'(s_q) << {cmd_i.bit_idx, 1'b0});
  assign take = (cand <= m_q) && (pc <= PC_W'(prod_q));

  assign dt_eff = (first_q || in_elapsed_i > tvrl_pkg::DT_MAX_US) ?
                  tvrl_pkg::DT_DEFAULT_US : in_elapsed_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.ang) begin
        sel_v[i]   = {vel_q[i+3][VW-1], vel_q[i+3]};
        store_v[i] = cmd_i.ramp ? ({prev_q[i+3][VW-1], prev_q[i+3]} + work_q[i])
                                : work_q[i];
        if (cmd_i.ramp) begin
          sel_v[i] = sel_v[i] - {prev_q[i+3][VW-1], prev_q[i+3]};
        end
      end else begin
        sel_v[i]   = {vel_q[i][VW-1], vel_q[i]};
        store_v[i] = cmd_i.ramp ? ({prev_q[i][VW-1], prev_q[i]} + work_q[i])
                                : work_q[i];
        if (cmd_i.ramp) begin
          sel_v[i] = sel_v[i] - {prev_q[i][VW-1], prev_q[i]};
        end
      end
    end
  end

  assign sts_o.over    = PR_W'(s_q) > prod_q;
  assign sts_o.ramp_en = ramp_en_q;

  // history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      for (int i = 0; i < 6; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cmd_i.op == tvrl_pkg::OP_RESET_HIST) begin
      first_q <= 1'b1;
      for (int i = 0; i < 6; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cmd_i.op == tvrl_pkg::OP_DONE) begin
      first_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        prev_q[i] <= vel_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tvrl_pkg::OP_LOAD: begin
        for (int i = 0; i < 6; i++) begin
          vel_q[i] <= in_vel_i[i];
        end
        dt_q      <= dt_eff;
        ramp_en_q <= !first_q && (dt_eff > tvrl_pkg::DT_MIN_US);
        flag_q    <= '0;
      end
      tvrl_pkg::OP_DIV_INIT: begin
        prod_q <= mul_p;
        quo_q  <= '0;
      end
      tvrl_pkg::OP_DIV_BIT: begin
        if (div_ge) begin
          prod_q <= prod_q - dvs;
        end
        quo_q[cmd_i.bit_idx] <= div_ge;
      end
      tvrl_pkg::OP_SEL: begin
        for (int i = 0; i < 3; i++) begin
          work_q[i] <= sel_v[i];
        end
        if (cmd_i.ramp) begin
          m_q <= quo_q;
        end else if (cmd_i.ang) begin
          m_q <= MW'(cfg_i.max_angular_speed);
        end else begin
          m_q <= MW'(cfg_i.max_linear_speed);
        end
        s_q <= '0;
      end
      tvrl_pkg::OP_SQ, tvrl_pkg::OP_MSQ, tvrl_pkg::OP_TMUL: begin
        prod_q <= mul_p;
      end
      tvrl_pkg::OP_ACC: begin
        s_q <= s_q + S_W'(prod_q);
      end
      tvrl_pkg::OP_CMP: begin
        over_q <= sts_o.over;
      end
      tvrl_pkg::OP_TSQ: begin
        prod_q <= mul_p;
        p_q    <= '0;
        q_q    <= '0;
        r_q    <= '0;
      end
      tvrl_pkg::OP_BIT: begin
        if (take) begin
          p_q <= pc;
          q_q <= q_q + (Q_W'(s_q) << cmd_i.bit_idx);
          r_q <= cand;
        end
      end
      tvrl_pkg::OP_WR: begin
        if (work_q[cmd_i.idx][VW]) begin
          work_q[cmd_i.idx] <= -$signed({1'b0, r_q});
        end else begin
          work_q[cmd_i.idx] <= $signed({1'b0, r_q});
        end
      end
      tvrl_pkg::OP_STORE: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd_i.ang) begin
            vel_q[i+3] <= store_v[i][VW-1:0];
          end else begin
            vel_q[i] <= store_v[i][VW-1:0];
          end
        end
        flag_q[{cmd_i.ramp, cmd_i.ang}] <= over_q;
      end
      tvrl_pkg::OP_DONE: begin
        for (int i = 0; i < 6; i++) begin
          res_vel_o[i] <= vel_q[i];
        end
        res_flag_o <= flag_q;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/tvrl_ctrl.sv
// ----------------------------------------------------------------------------
// tvrl_ctrl
// Sequencer: steps the datapath through clamp, divide and ramp phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvrl_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wire             in_cmd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  tvrl_pkg::sts_t  sts_i,
  output tvrl_pkg::cmd_t  cmd_o
);

  localparam logic [tvrl_pkg::BIT_W-1:0] BIT_TOP = tvrl_pkg::BIT_W'(tvrl_pkg::M_W - 1);

  tvrl_pkg::state_e state_q, state_d;
  logic [1:0]                 idx_q;
  logic [tvrl_pkg::BIT_W-1:0] bit_q;
  logic                       ang_q;
  logic                       ramp_q;
  logic                       out_valid_q;
  logic                       done_go;

  assign done_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tvrl_pkg::ST_IDLE: begin
        if (in_valid_i && !in_cmd_i) state_d = tvrl_pkg::ST_SEL;
      end
      tvrl_pkg::ST_DIV_INIT: state_d = tvrl_pkg::ST_DIV;
      tvrl_pkg::ST_DIV: begin
        if (bit_q == '0) state_d = tvrl_pkg::ST_SEL;
      end
      tvrl_pkg::ST_SEL: state_d = tvrl_pkg::ST_SQ;
      tvrl_pkg::ST_SQ:  state_d = tvrl_pkg::ST_ACC;
      tvrl_pkg::ST_ACC: begin
        state_d = (idx_q == 2'd2) ? tvrl_pkg::ST_MSQ : tvrl_pkg::ST_SQ;
      end
      tvrl_pkg::ST_MSQ: state_d = tvrl_pkg::ST_CMP;
      tvrl_pkg::ST_CMP: begin
        state_d = sts_i.over ? tvrl_pkg::ST_TMUL : tvrl_pkg::ST_STORE;
      end
      tvrl_pkg::ST_TMUL: state_d = tvrl_pkg::ST_TSQ;
      tvrl_pkg::ST_TSQ:  state_d = tvrl_pkg::ST_BIT;
      tvrl_pkg::ST_BIT: begin
        if (bit_q == '0) state_d = tvrl_pkg::ST_WR;
      end
      tvrl_pkg::ST_WR: begin
        state_d = (idx_q == 2'd2) ? tvrl_pkg::ST_STORE : tvrl_pkg::ST_TMUL;
      end
      tvrl_pkg::ST_STORE: begin
        if (!ang_q) begin
          state_d = ramp_q ? tvrl_pkg::ST_DIV_INIT : tvrl_pkg::ST_SEL;
        end else if (!ramp_q && sts_i.ramp_en) begin
          state_d = tvrl_pkg::ST_DIV_INIT;
        end else begin
          state_d = tvrl_pkg::ST_DONE;
        end
      end
      tvrl_pkg::ST_DONE: begin
        if (done_go) state_d = tvrl_pkg::ST_IDLE;
      end
      default: state_d = tvrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op      = tvrl_pkg::OP_NONE;
    cmd_o.idx     = idx_q;
    cmd_o.bit_idx = bit_q;
    cmd_o.ang     = ang_q;
    cmd_o.ramp    = ramp_q;
    in_ready_o    = 1'b0;
    case (state_q)
      tvrl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = in_cmd_i ? tvrl_pkg::OP_RESET_HIST : tvrl_pkg::OP_LOAD;
        end
      end
      tvrl_pkg::ST_DIV_INIT: cmd_o.op = tvrl_pkg::OP_DIV_INIT;
      tvrl_pkg::ST_DIV:      cmd_o.op = tvrl_pkg::OP_DIV_BIT;
      tvrl_pkg::ST_SEL:      cmd_o.op = tvrl_pkg::OP_SEL;
      tvrl_pkg::ST_SQ:       cmd_o.op = tvrl_pkg::OP_SQ;
      tvrl_pkg::ST_ACC:      cmd_o.op = tvrl_pkg::OP_ACC;
      tvrl_pkg::ST_MSQ:      cmd_o.op = tvrl_pkg::OP_MSQ;
      tvrl_pkg::ST_CMP:      cmd_o.op = tvrl_pkg::OP_CMP;
      tvrl_pkg::ST_TMUL:     cmd_o.op = tvrl_pkg::OP_TMUL;
      tvrl_pkg::ST_TSQ:      cmd_o.op = tvrl_pkg::OP_TSQ;
      tvrl_pkg::ST_BIT:      cmd_o.op = tvrl_pkg::OP_BIT;
      tvrl_pkg::ST_WR:       cmd_o.op = tvrl_pkg::OP_WR;
      tvrl_pkg::ST_STORE:    cmd_o.op = tvrl_pkg::OP_STORE;
      tvrl_pkg::ST_DONE: begin
        if (done_go) cmd_o.op = tvrl_pkg::OP_DONE;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tvrl_pkg::ST_IDLE;
      idx_q       <= '0;
      bit_q       <= '0;
      ang_q       <= 1'b0;
      ramp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tvrl_pkg::ST_DONE && done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        tvrl_pkg::ST_IDLE: begin
          ang_q  <= 1'b0;
          ramp_q <= 1'b0;
        end
        tvrl_pkg::ST_DIV_INIT, tvrl_pkg::ST_TSQ: bit_q <= BIT_TOP;
        tvrl_pkg::ST_DIV, tvrl_pkg::ST_BIT:      bit_q <= bit_q - 1'b1;
        tvrl_pkg::ST_SEL, tvrl_pkg::ST_CMP:      idx_q <= '0;
        tvrl_pkg::ST_ACC, tvrl_pkg::ST_WR:       idx_q <= idx_q + 1'b1;
        tvrl_pkg::ST_STORE: begin
          if (!ang_q) begin
            ang_q <= 1'b1;
          end else if (!ramp_q) begin
            ramp_q <= 1'b1;
            ang_q  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/twist_velocity_ramp_limiter.sv
// ----------------------------------------------------------------------------
// twist_velocity_ramp_limiter
// Speed and acceleration limiter for a 6-axis velocity command.
//
// in_i takes one command beat when ready is high; ready is high only while
// the block is idle. cmd 1 clears the history and gives no output beat.
// cmd 0 gives one out_o beat: linear and angular vectors clamped to their
// speed limits, then (after the first sample, dt over 1 ms) the change from
// the last output clamped to accel * dt. Limits sit in four APB registers.
// Each clamp pass sums squares on one shared multiplier, and a vector over
// its limit is scaled bit-serially, one component after another; each ramp
// pass first runs a bit-serial divide of accel * dt by one second.
// A finished beat waits in the output register; the next command is taken
// meanwhile, and the block stalls at the end of that one until out_o drains.
// Reset clears the history and restores the default limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twist_velocity_ramp_limiter #(
  parameter int unsigned VEL_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  tvrl_in_if.sink                          in_i,
  tvrl_out_if.source                       out_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tvrl_pkg::APB_AW-1:0]       paddr,
  input  wire [tvrl_pkg::APB_DW-1:0]       pwdata,
  output logic [tvrl_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  tvrl_pkg::cfg_t cfg_q;
  tvrl_pkg::cmd_t cmd;
  tvrl_pkg::sts_t sts;
  logic signed [VEL_WIDTH-1:0] in_vel [6];
  logic signed [VEL_WIDTH-1:0] res_vel [6];
  logic [3:0]                  res_flag;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_linear_speed  <= tvrl_pkg::LIN_SPEED_RST;
      cfg_q.max_angular_speed <= tvrl_pkg::ANG_SPEED_RST;
      cfg_q.max_linear_accel  <= tvrl_pkg::LIN_ACCEL_RST;
      cfg_q.max_angular_accel <= tvrl_pkg::ANG_ACCEL_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        tvrl_pkg::REG_LIN_SPEED: cfg_q.max_linear_speed  <= pwdata[tvrl_pkg::SPD_W-1:0];
        tvrl_pkg::REG_ANG_SPEED: cfg_q.max_angular_speed <= pwdata[tvrl_pkg::SPD_W-1:0];
        tvrl_pkg::REG_LIN_ACCEL: cfg_q.max_linear_accel  <= pwdata[tvrl_pkg::ACC_W-1:0];
        tvrl_pkg::REG_ANG_ACCEL: cfg_q.max_angular_accel <= pwdata[tvrl_pkg::ACC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tvrl_pkg::REG_LIN_SPEED: prdata = tvrl_pkg::APB_DW'(cfg_q.max_linear_speed);
      tvrl_pkg::REG_ANG_SPEED: prdata = tvrl_pkg::APB_DW'(cfg_q.max_angular_speed);
      tvrl_pkg::REG_LIN_ACCEL: prdata = tvrl_pkg::APB_DW'(cfg_q.max_linear_accel);
      tvrl_pkg::REG_ANG_ACCEL: prdata = tvrl_pkg::APB_DW'(cfg_q.max_angular_accel);
      default:                 prdata = '0;
    endcase
  end

  assign in_vel[0] = in_i.lin_x;
  assign in_vel[1] = in_i.lin_y;
  assign in_vel[2] = in_i.lin_z;
  assign in_vel[3] = in_i.ang_x;
  assign in_vel[4] = in_i.ang_y;
  assign in_vel[5] = in_i.ang_z;

  tvrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tvrl_dp #(
    .VEL_WIDTH (VEL_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg_q),
    .in_vel_i     (in_vel),
    .in_elapsed_i (in_i.elapsed_us),
    .res_vel_o    (res_vel),
    .res_flag_o   (res_flag)
  );

  assign out_o.out_lin_x         = res_vel[0];
  assign out_o.out_lin_y         = res_vel[1];
  assign out_o.out_lin_z         = res_vel[2];
  assign out_o.out_ang_x         = res_vel[3];
  assign out_o.out_ang_y         = res_vel[4];
  assign out_o.out_ang_z         = res_vel[5];
  assign out_o.lin_speed_clamped = res_flag[0];
  assign out_o.ang_speed_clamped = res_flag[1];
  assign out_o.lin_accel_clamped = res_flag[2];
  assign out_o.ang_accel_clamped = res_flag[3];

endmodule

`default_nettype wire

// File: verif/twist_velocity_ramp_limiter_tb.sv
// ----------------------------------------------------------------------------
// twist_velocity_ramp_limiter_tb
// Self-checking bench: drives velocity commands and APB limit writes, predicts
// every output beat with an exact integer model and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twist_velocity_ramp_limiter_tb;

  typedef struct packed {
    logic                          cmd;
    logic signed [15:0]            lx, ly, lz, ax, ay, az;
    logic [tvrl_pkg::DT_W-1:0]     dt;
  } vel_cmd_t;

  typedef struct packed {
    logic signed [15:0] lx, ly, lz, ax, ay, az;
    logic ls, as_, la, aa;
  } vel_res_t;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tvrl_pkg::APB_AW-1:0] paddr = '0;
  logic [tvrl_pkg::APB_DW-1:0] pwdata = '0;
  logic [tvrl_pkg::APB_DW-1:0] prdata;
  logic pready;

  tvrl_in_if  #(.VEL_WIDTH(16)) in_if ();
  tvrl_out_if #(.VEL_WIDTH(16)) out_if ();

  twist_velocity_ramp_limiter #(.VEL_WIDTH(16)) dut (
    .clk_i, .rst_ni, .in_i(in_if.sink), .out_o(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint hist_lin[3], hist_ang[3];
  bit     first_pending;
  longint lim_lin_spd, lim_ang_spd, lim_lin_acc, lim_ang_acc;

  vel_res_t expected_beats[$];
  int  mismatches;
  int  src_idle_pct, snk_stall_pct;
  longint cycles;

  // scales a to norm m; 128-bit exact arithmetic
  function automatic bit clamp_to_norm(inout longint a[3], input longint m);
    logic [127:0] s, tgt, mm;
    longint unsigned u, r, cand;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      u = (a[i] < 0) ? -a[i] : a[i];
      s += 128'(u) * 128'(u);
    end
    mm = 128'(m) * 128'(m);
    if (s <= mm) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      u = ((a[i] < 0) ? -a[i] : a[i]) * m;
      tgt = 128'(u) * 128'(u);
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (cand <= m && s * 128'(cand * cand) <= tgt) r = cand;
      end
      a[i] = (a[i] < 0) ? -longint'(r) : longint'(r);
    end
    return 1'b1;
  endfunction

  function automatic bit ramp_toward(inout longint v[3], input longint p[3],
                                     input longint inc);
    longint d[3];
    bit hit;
    for (int i = 0; i < 3; i++) d[i] = v[i] - p[i];
    hit = clamp_to_norm(d, inc);
    if (hit) for (int i = 0; i < 3; i++) v[i] = p[i] + d[i];
    return hit;
  endfunction

  task automatic predict_limited(input vel_cmd_t c);
    longint v[3], w[3], dt;
    vel_res_t r;
    if (c.cmd) begin
      foreach (hist_lin[i]) begin
        hist_lin[i] = 0;
        hist_ang[i] = 0;
      end
      first_pending = 1'b1;
      return;
    end
    v = '{c.lx, c.ly, c.lz};
    w = '{c.ax, c.ay, c.az};
    dt = c.dt;
    if (first_pending || dt > tvrl_pkg::DT_MAX_US) dt = tvrl_pkg::DT_DEFAULT_US;
    r = '0;
    r.ls = clamp_to_norm(v, lim_lin_spd);
    r.as_ = clamp_to_norm(w, lim_ang_spd);
    if (!first_pending && dt > tvrl_pkg::DT_MIN_US) begin
      r.la = ramp_toward(v, hist_lin, lim_lin_acc * dt / tvrl_pkg::US_PER_S);
      r.aa = ramp_toward(w, hist_ang, lim_ang_acc * dt / tvrl_pkg::US_PER_S);
    end
    hist_lin = v;
    hist_ang = w;
    first_pending = 1'b0;
    r.lx = v[0]; r.ly = v[1]; r.lz = v[2];
    r.ax = w[0]; r.ay = w[1]; r.az = w[2];
    expected_beats.push_back(r);
  endtask

  // output checker and sink stalls
  always @(posedge clk_i) begin
    vel_res_t got, exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.out_lin_x, out_if.out_lin_y, out_if.out_lin_z,
              out_if.out_ang_x, out_if.out_ang_y, out_if.out_ang_z,
              out_if.lin_speed_clamped, out_if.ang_speed_clamped,
              out_if.lin_accel_clamped, out_if.ang_accel_clamped};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        exp_r = expected_beats.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch exp %p got %p", exp_r, got);
        end
      end
    end
  end

  always @(negedge clk_i)
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= tvrl_pkg::APB_AW'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tvrl_pkg::REG_LIN_SPEED: lim_lin_spd = val[14:0];
      tvrl_pkg::REG_ANG_SPEED: lim_ang_spd = val[14:0];
      tvrl_pkg::REG_LIN_ACCEL: lim_lin_acc = val[15:0];
      default:                 lim_ang_acc = val[15:0];
    endcase
  endtask

  // valid stays high after the beat so the next one can follow directly
  task automatic send_cmd(input vel_cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    {in_if.cmd, in_if.lin_x, in_if.lin_y, in_if.lin_z, in_if.ang_x, in_if.ang_y,
     in_if.ang_z, in_if.elapsed_us} <= c;
    do @(posedge clk_i); while (!in_if.ready);
    predict_limited(c);
  endtask

  // drain, then idle long enough for a trailing cmd 1 to finish
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic vel_cmd_t rand_cmd(input int span);
    vel_cmd_t c;
    c.cmd = ($urandom_range(29) == 0);
    c.lx = $signed($urandom_range(2 * span)) - span;
    c.ly = $signed($urandom_range(2 * span)) - span;
    c.lz = $signed($urandom_range(2 * span)) - span;
    c.ax = $signed($urandom_range(2 * span)) - span;
    c.ay = $signed($urandom_range(2 * span)) - span;
    c.az = $signed($urandom_range(2 * span)) - span;
    case ($urandom_range(5))
      0: c.dt = $urandom();
      1: c.dt = $urandom_range(1200);
      default: c.dt = $urandom_range(200000, 900);
    endcase
    return c;
  endfunction

  task automatic test_directed();
    send_cmd('{1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
               -16'sh8000, 20'd0});
    send_cmd('{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1000});
    send_cmd('{1'b0, 16'sd100, -16'sd50, 16'sd7, 16'sd1, 16'sd2, -16'sd3, 20'd1001});
    send_cmd('{1'b0, -16'sh8000, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0,
               20'hfffff});
    send_cmd('{1'b0, 16'sd500, 16'sd500, 16'sd0, -16'sd900, 16'sd900, 16'sd0,
               20'd1000000});
    send_cmd('{1'b0, 16'sd0, 16'sd0, 16'sd819, 16'sd0, 16'sd2048, 16'sd0,
               20'd1000001});
    send_cmd('{1'b1, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
               16'shffff, 20'hfffff});
    send_cmd('{1'b0, 16'sd300, 16'sd300, 16'sd300, 16'sd800, 16'sd0, 16'sd0,
               20'd2000});
    send_cmd('{1'b0, -16'sd300, -16'sd300, 16'sd300, -16'sd800, 16'sd0, 16'sd0,
               20'd2000});
    wait_drained();
    // zero limits, then extremes
    apb_write(tvrl_pkg::REG_LIN_SPEED, 32'hffff_0000);
    apb_write(tvrl_pkg::REG_ANG_SPEED, 32'd0);
    apb_write(tvrl_pkg::REG_LIN_ACCEL, 32'd0);
    apb_write(tvrl_pkg::REG_ANG_ACCEL, 32'hffff_0000);
    send_cmd('{1'b0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 20'd5000});
    send_cmd('{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd5000});
    wait_drained();
    apb_write(tvrl_pkg::REG_LIN_SPEED, 32'hffff_ffff);
    apb_write(tvrl_pkg::REG_ANG_SPEED, 32'h7fff);
    apb_write(tvrl_pkg::REG_LIN_ACCEL, 32'hffff_ffff);
    apb_write(tvrl_pkg::REG_ANG_ACCEL, 32'd0);
    send_cmd('{1'b0, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'sd1, 16'sd1, 16'sd1,
               20'd3000});
    send_cmd('{1'b0, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sd9, 16'sd9, 16'sd9,
               20'd999999});
    wait_drained();
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall,
                                   input int span);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < n; i++) send_cmd(rand_cmd(span));
    src_idle_pct = 0;
    snk_stall_pct = 0;
    wait_drained();
  endtask

  task automatic test_random_limits();
    apb_write(tvrl_pkg::REG_LIN_SPEED, $urandom_range(32767));
    apb_write(tvrl_pkg::REG_ANG_SPEED, $urandom_range(32767));
    apb_write(tvrl_pkg::REG_LIN_ACCEL, $urandom_range(65535));
    apb_write(tvrl_pkg::REG_ANG_ACCEL, $urandom);
  endtask

  initial begin
    in_if.valid = 1'b0;
    {in_if.cmd, in_if.lin_x, in_if.lin_y, in_if.lin_z, in_if.ang_x, in_if.ang_y,
     in_if.ang_z, in_if.elapsed_us} = '0;
    out_if.ready = 1'b0;
    cycles = 0;
    mismatches = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    foreach (hist_lin[i]) begin
      hist_lin[i] = 0;
      hist_ang[i] = 0;
    end
    first_pending = 1'b1;
    lim_lin_spd = tvrl_pkg::LIN_SPEED_RST;
    lim_ang_spd = tvrl_pkg::ANG_SPEED_RST;
    lim_lin_acc = tvrl_pkg::LIN_ACCEL_RST;
    lim_ang_acc = tvrl_pkg::ANG_ACCEL_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_random_phase(150, 0, 0, 2000);   // default limits
    test_directed();
    test_random_limits();
    test_random_phase(300, 0, 0, 32767);
    test_random_limits();
    test_random_phase(300, 57, 0, 4000);
    test_random_limits();
    test_random_phase(300, 0, 57, 32767);
    test_random_limits();
    test_random_phase(300, 34, 34, 3000);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: sim.f
src/tvrl_pkg.sv
src/tvrl_in_if.sv
src/tvrl_out_if.sv
src/tvrl_dp.sv
src/tvrl_ctrl.sv
src/twist_velocity_ramp_limiter.sv
verif/twist_velocity_ramp_limiter_tb.sv
